// ----- rtl/bvot_pkg.sv -----
// Shared types and constants for the bounding volume overlap test.
package bvot_pkg;

  localparam int FIELD_BITS = 32;
  localparam int NUM_COORDS = 6;
  localparam int CFG_ADDR_BITS = 3;

  typedef enum logic [1:0] {
    KIND_BOX    = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_POINT  = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  localparam logic [CFG_ADDR_BITS-1:0] REG_KIND     = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_X  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SECOND_Z = 3'd6;

  typedef struct packed {
    logic simple_hit;
    logic use_dist;
    logic bad;
  } ctl_t;

endpackage

// ----- rtl/bvot_prep.sv -----
// Front stage: pair decode, box tests, clamp and radius select.
module bvot_prep #(
  parameter int COORD_BITS = 32
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  bvot_pkg::kind_t                                 q_kind,
  input  logic [bvot_pkg::NUM_COORDS-1:0][bvot_pkg::FIELD_BITS-1:0] q_raw,
  input  bvot_pkg::kind_t                                 o_kind,
  input  logic [bvot_pkg::NUM_COORDS-1:0][bvot_pkg::FIELD_BITS-1:0] o_raw,
  output logic                                            v_r,
  output bvot_pkg::ctl_t                                  ctl_r,
  output logic [2:0][COORD_BITS-1:0]                      u_r,
  output logic [2:0][COORD_BITS-1:0]                      p_r,
  output logic [COORD_BITS:0]                             rad_r
);
  import bvot_pkg::*;

  localparam int CW = COORD_BITS;

  logic [NUM_COORDS-1:0][CW-1:0] qc;
  logic [NUM_COORDS-1:0][CW-1:0] oc;
  logic [2:0][CW-1:0] bmin, bmax, pt, clamped, near;
  logic [2:0][CW-1:0] u_nxt, p_nxt;
  logic [CW:0] rad_nxt;
  logic [CW:0] qr, orad;
  logic box_is_q, in_box, bb_ovl, eq;
  ctl_t ctl_nxt;

  for (genvar g = 0; g < NUM_COORDS; g++) begin : g_ext
    if (CW <= FIELD_BITS) begin : g_trunc
      assign qc[g] = q_raw[g][CW-1:0];
      assign oc[g] = o_raw[g][CW-1:0];
    end else begin : g_zext
      assign qc[g] = {{(CW-FIELD_BITS){1'b0}}, q_raw[g]};
      assign oc[g] = {{(CW-FIELD_BITS){1'b0}}, o_raw[g]};
    end
  end

  assign qr   = {qc[3][CW-1], qc[3]};
  assign orad = {oc[3][CW-1], oc[3]};

  always_comb begin
    box_is_q = (q_kind == KIND_BOX);
    in_box = 1'b1;
    bb_ovl = 1'b1;
    eq = 1'b1;
    for (int i = 0; i < 3; i++) begin
      bmin[i] = box_is_q ? qc[i] : oc[i];
      bmax[i] = box_is_q ? qc[3+i] : oc[3+i];
      pt[i]   = box_is_q ? oc[i] : qc[i];
      in_box = in_box && ($signed(pt[i]) >= $signed(bmin[i]))
                      && ($signed(pt[i]) <= $signed(bmax[i]));
      clamped[i] = ($signed(pt[i]) < $signed(bmax[i])) ? pt[i] : bmax[i];
      near[i] = ($signed(clamped[i]) > $signed(bmin[i])) ? clamped[i] : bmin[i];
      bb_ovl = bb_ovl && ($signed(qc[i]) <= $signed(oc[3+i]))
                      && ($signed(qc[3+i]) >= $signed(oc[i]));
      eq = eq && (qc[i] == oc[i]);
    end

    ctl_nxt.simple_hit = 1'b0;
    ctl_nxt.use_dist   = 1'b0;
    ctl_nxt.bad        = (o_kind == KIND_BAD);
    u_nxt   = qc[2:0];
    p_nxt   = oc[2:0];
    rad_nxt = qr;

    case (q_kind)
      KIND_BOX: begin
        case (o_kind)
          KIND_BOX:    ctl_nxt.simple_hit = bb_ovl;
          KIND_SPHERE: begin
            ctl_nxt.use_dist = 1'b1;
            u_nxt = pt;
            p_nxt = near;
            rad_nxt = orad;
          end
          KIND_POINT:  ctl_nxt.simple_hit = in_box;
          default: ;
        endcase
      end
      KIND_SPHERE: begin
        case (o_kind)
          KIND_BOX: begin
            ctl_nxt.use_dist = 1'b1;
            u_nxt = pt;
            p_nxt = near;
          end
          KIND_SPHERE: begin
            ctl_nxt.use_dist = 1'b1;
            rad_nxt = qr + orad;
          end
          KIND_POINT:  ctl_nxt.use_dist = 1'b1;
          default: ;
        endcase
      end
      KIND_POINT: begin
        case (o_kind)
          KIND_BOX:    ctl_nxt.simple_hit = in_box;
          KIND_SPHERE: begin
            ctl_nxt.use_dist = 1'b1;
            rad_nxt = orad;
          end
          KIND_POINT:  ctl_nxt.simple_hit = eq;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt;
      u_r   <= u_nxt;
      p_r   <= p_nxt;
      rad_r <= rad_nxt;
    end
  end

endmodule

// ----- rtl/bvot_sqr.sv -----
// Two-stage squarer built from half-width partial products.
module bvot_sqr #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [WIDTH-1:0]   x,
  output logic [2*WIDTH-1:0] sq_r
);
  import bvot_pkg::*;

  localparam int L  = WIDTH / 2;
  localparam int H  = WIDTH - L;
  localparam int HH = 2 * H;
  localparam int LL = 2 * L;
  localparam int SW = 2 * WIDTH;

  logic [H-1:0]     xh;
  logic [L-1:0]     xl;
  logic [HH-1:0]    hh_r;
  logic [WIDTH-1:0] hl_r;
  logic [LL-1:0]    ll_r;
  logic [SW-1:0]    sq_nxt;

  assign xh = x[WIDTH-1:L];
  assign xl = x[L-1:0];

  assign sq_nxt = {hh_r, {LL{1'b0}}}
                + {{(H-1){1'b0}}, hl_r, {(L+1){1'b0}}}
                + {{HH{1'b0}}, ll_r};

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= HH'(xh) * HH'(xh);
      hl_r <= WIDTH'(xh) * WIDTH'(xl);
      ll_r <= LL'(xl) * LL'(xl);
      sq_r <= sq_nxt;
    end
  end

endmodule

// ----- rtl/bounding_volume_overlap_test.sv -----
// Throughput: one item per cycle unless stalled; the six register stages advance together.
// A stalled output holds every stage, and in_tready follows the output side.
// Reset (rst_n low, synchronous) clears all valid bits and the query to a box at the origin.
// Top level: query registers, distance stages, compare and output register.
module bounding_volume_overlap_test #(
  parameter int COORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // obj_first_x, obj_first_y, obj_first_z, obj_second_x, obj_second_y, obj_second_z
  input  logic [191:0] in_tdata,
  // obj_kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit, zero padding
  output logic [7:0]   out_tdata,
  // bad_kind
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [bvot_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import bvot_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int SW = 2 * CW;
  localparam int DW = SW + 2;

  kind_t query_kind_r;
  logic [NUM_COORDS-1:0][FIELD_BITS-1:0] query_coord_r;
  logic [NUM_COORDS-1:0][FIELD_BITS-1:0] obj_coord;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_tvalid_r;
  ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  ctl_t ctl2_nxt;
  logic [2:0][CW-1:0] u1_r, p1_r;
  logic [CW:0] rad1_r;
  logic [2:0][CW-1:0] d_r, d_nxt;
  logic [CW-1:0] m_r;
  logic [CW:0] diff [3];
  logic [3:0][SW-1:0] sq;
  logic [DW-1:0] dsum_r, dsum_nxt;
  logic [SW-1:0] r2_r;
  logic hit_r, bad_r, hit_nxt;

  assign adv = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_kind_r  <= KIND_BOX;
      query_coord_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_KIND) begin
        query_kind_r <= kind_t'(cfg_wdata[1:0]);
      end else if (cfg_addr >= REG_FIRST_X && cfg_addr <= REG_SECOND_Z) begin
        query_coord_r[cfg_addr - REG_FIRST_X] <= cfg_wdata;
      end
    end
  end

  for (genvar g = 0; g < NUM_COORDS; g++) begin : g_obj
    assign obj_coord[g] = in_tdata[g*FIELD_BITS +: FIELD_BITS];
  end

  bvot_prep #(.COORD_BITS(CW)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .q_kind   (query_kind_r),
    .q_raw    (query_coord_r),
    .o_kind   (kind_t'(in_tuser)),
    .o_raw    (obj_coord),
    .v_r      (v1_r),
    .ctl_r    (ctl1_r),
    .u_r      (u1_r),
    .p_r      (p1_r),
    .rad_r    (rad1_r)
  );

  // stage 2: absolute differences, radius sign folded into control
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {u1_r[i][CW-1], u1_r[i]} - {p1_r[i][CW-1], p1_r[i]};
      d_nxt[i] = diff[i][CW] ? CW'(-diff[i]) : diff[i][CW-1:0];
    end
    ctl2_nxt = ctl1_r;
    ctl2_nxt.use_dist = ctl1_r.use_dist & ~rad1_r[CW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r    <= d_nxt;
      m_r    <= rad1_r[CW-1:0];
      ctl2_r <= ctl2_nxt;
    end
  end

  // stages 3 and 4: squares
  for (genvar g = 0; g < 4; g++) begin : g_sqr
    bvot_sqr #(.WIDTH(CW)) u_sqr (
      .clk  (clk),
      .en   (adv),
      .x    ((g < 3) ? d_r[g % 3] : m_r),
      .sq_r (sq[g])
    );
  end

  // stage 5: squared distance, then the compare into the output register
  assign dsum_nxt = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

  assign hit_nxt = ctl5_r.simple_hit
                 | (ctl5_r.use_dist & (dsum_r <= {2'b00, r2_r}));

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      dsum_r <= dsum_nxt;
      r2_r   <= sq[3];
      hit_r  <= hit_nxt;
      bad_r  <= ctl5_r.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_tvalid_r <= v5_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, hit_r};
  assign out_tuser  = bad_r;

`ifndef SYNTHESIS
  a_bad_no_hit : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tuser[0]))
    else $error("hit raised on a bad kind item");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted item missing from first stage");

  a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  a_out_from_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v5_r))
    else $error("output valid without a stage five item");
`endif

endmodule

// ----- bench/tb_bounding_volume_overlap_test.sv -----
// Self-checking testbench: streams objects against box, sphere and point query volumes and an invalid query kind.
module tb_bounding_volume_overlap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bvot_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int RANDOM_PHASES = 12;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD_AT = 400;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;

  typedef struct packed {
    kind_t            kind;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
  } volume_t;

  typedef struct packed {
    logic hit;
    logic bad;
  } overlap_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;

  volume_t  query = '0;
  volume_t  cur_obj;
  volume_t  pending_objects[$];
  overlap_t expected_overlaps[$];
  int unsigned send_gap = 0, send_burst = 0, recv_wait = 0, recv_burst = 0;
  int unsigned idle_cycles = 0;
  bit long_hold_done = 0;
  int n_queued = 0, n_accepted = 0, n_results = 0, n_errors = 0;
  int n_settings = 0, n_hits = 0, n_bad = 0;

  bounding_volume_overlap_test i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------- overlap predictor ----------------
  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [71:0] square(longint unsigned m);
    return 72'(m) * 72'(m);
  endfunction

  function automatic logic [71:0] dist_sq(logic [2:0][31:0] p, logic [2:0][31:0] q);
    logic [71:0] s;
    longint d;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      d = sx(p[i]) - sx(q[i]);
      s += square(d < 0 ? -d : d);
    end
    return s;
  endfunction

  function automatic logic in_radius(logic [2:0][31:0] c, logic [2:0][31:0] p, longint r);
    if (r < 0) return 1'b0;
    return dist_sq(c, p) <= square(r);
  endfunction

  // clamp: min against max first, then max against min, no fix-up of inverted boxes
  function automatic logic box_sphere(volume_t box, volume_t sph);
    logic [2:0][31:0] near;
    longint c;
    for (int i = 0; i < 3; i++) begin
      c = sx(sph.a[i]);
      if (c > sx(box.b[i])) c = sx(box.b[i]);
      if (c < sx(box.a[i])) c = sx(box.a[i]);
      near[i] = c[31:0];
    end
    return in_radius(sph.a, near, sx(sph.b[0]));
  endfunction

  function automatic logic box_point(volume_t box, logic [2:0][31:0] p);
    for (int i = 0; i < 3; i++)
      if (!(sx(p[i]) >= sx(box.a[i]) && sx(p[i]) <= sx(box.b[i]))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic box_box(volume_t u, volume_t v);
    for (int i = 0; i < 3; i++)
      if (!(sx(u.a[i]) <= sx(v.b[i]) && sx(u.b[i]) >= sx(v.a[i]))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic overlap_t predict_overlap(volume_t q, volume_t o);
    overlap_t r;
    r = '0;
    if (o.kind == KIND_BAD) begin
      r.bad = 1'b1;
    end else begin
      case (q.kind)
        KIND_BOX: begin
          case (o.kind)
            KIND_BOX:    r.hit = box_box(q, o);
            KIND_SPHERE: r.hit = box_sphere(q, o);
            default:     r.hit = box_point(q, o.a);
          endcase
        end
        KIND_SPHERE: begin
          case (o.kind)
            KIND_BOX:    r.hit = box_sphere(o, q);
            KIND_SPHERE: r.hit = in_radius(q.a, o.a, sx(q.b[0]) + sx(o.b[0]));
            default:     r.hit = in_radius(q.a, o.a, sx(q.b[0]));
          endcase
        end
        KIND_POINT: begin
          case (o.kind)
            KIND_BOX:    r.hit = box_point(o, q.a);
            KIND_SPHERE: r.hit = in_radius(o.a, q.a, sx(o.b[0]));
            default:     r.hit = (q.a == o.a);
          endcase
        end
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

  // ---------------- random shaping ----------------
  function automatic int unsigned draw_wait(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [31:0] magnitude();
    return $urandom >> $urandom_range(6, 31);
  endfunction

  function automatic logic [31:0] pick_coord(logic [31:0] base);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom_range(0, 1) ? base + magnitude() : base - magnitude();
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return -magnitude() - 1;
      2: return 32'h0;
      default: return magnitude();
    endcase
  endfunction

  function automatic volume_t rand_object();
    volume_t o;
    int unsigned r;
    r = $urandom_range(0, 9);
    o.kind = (r == 0) ? KIND_BAD : kind_t'(r % 3);
    for (int i = 0; i < 3; i++) begin
      o.a[i] = pick_coord($urandom_range(0, 3) == 0 ? query.b[i] : query.a[i]);
      o.b[i] = $urandom;
    end
    if (o.kind == KIND_BOX) begin
      for (int i = 0; i < 3; i++)
        o.b[i] = ($urandom_range(0, 7) == 0) ? pick_coord(query.b[i]) : o.a[i] + magnitude();
    end else if (o.kind == KIND_SPHERE) begin
      o.b[0] = rand_radius();
    end
    return o;
  endfunction

  function automatic volume_t rand_query();
    volume_t q;
    q.kind = ($urandom_range(0, 15) == 0) ? KIND_BAD : kind_t'($urandom_range(0, 2));
    for (int i = 0; i < 3; i++) begin
      q.a[i] = pick_coord(32'h0);
      q.b[i] = ($urandom_range(0, 7) == 0) ? pick_coord(32'h0) : q.a[i] + magnitude();
    end
    if (q.kind == KIND_SPHERE) q.b[0] = rand_radius();
    return q;
  endfunction

  function automatic volume_t make_obj(kind_t k, logic [31:0] ax, logic [31:0] ay,
                                       logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                       logic [31:0] bz);
    volume_t o;
    o.kind = k;
    o.a = {az, ay, ax};
    o.b = {bz, by, bx};
    return o;
  endfunction

  // ---------------- configuration and sequencing ----------------
  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == REG_KIND) query.kind = kind_t'(val[1:0]);
    else if (idx <= REG_SECOND_Z) begin
      if (idx < REG_FIRST_X + 3) query.a[idx - REG_FIRST_X] = val;
      else query.b[idx - REG_FIRST_X - 3] = val;
    end
  endtask

  task automatic load_query(volume_t v);
    write_reg(REG_KIND, 32'(v.kind));
    for (int i = 0; i < 3; i++) write_reg(CFG_ADDR_BITS'(REG_FIRST_X + i), v.a[i]);
    for (int i = 0; i < 3; i++) write_reg(CFG_ADDR_BITS'(REG_FIRST_X + 3 + i), v.b[i]);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic offer(volume_t o);
    pending_objects.push_back(o);
    n_queued++;
  endtask

  task automatic drain();
    do @(posedge clk); while (n_accepted != n_queued || expected_overlaps.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------- input driver ----------------
  always @(posedge clk) begin : item_driver
    logic take;
    overlap_t want;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      take = !in_tvalid || in_tready;
      if (in_tvalid && in_tready) begin
        want = predict_overlap(query, cur_obj);
        expected_overlaps.push_back(want);
        n_accepted++;
        n_hits += want.hit;
        n_bad += want.bad;
      end
      if (take) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_objects.size() > 0) begin
          cur_obj = pending_objects.pop_front();
          in_tdata <= {cur_obj.b, cur_obj.a};
          in_tuser <= cur_obj.kind;
          in_tvalid <= 1'b1;
          send_gap = draw_wait(send_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------
  always @(posedge clk) begin : result_monitor
    overlap_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_overlaps.size() == 0) begin
          $error("result with no item outstanding: hit %0b bad_kind %0b",
                 out_tdata[0], out_tuser[0]);
          n_errors++;
        end else begin
          want = expected_overlaps.pop_front();
          if (out_tdata[0] !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, out_tdata[0]);
            n_errors++;
          end
          if (out_tuser[0] !== want.bad) begin
            $error("bad_kind: expected %0b, actual %0b", want.bad, out_tuser[0]);
            n_errors++;
          end
        end
        n_results++;
        // long back-pressure so the pipeline fills and in_tready drops
        if (!long_hold_done && n_results == LONG_HOLD_AT) begin
          recv_wait = LONG_HOLD_CYCLES;
          long_hold_done = 1;
        end else begin
          recv_wait = draw_wait(recv_burst);
        end
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_tready <= (recv_wait == 0);
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_bounding_volume_overlap_test NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset query: box collapsed to the origin
    offer(make_obj(KIND_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    offer(make_obj(KIND_BOX, 1, 1, 1, -1, -1, -1));
    offer(make_obj(KIND_POINT, 0, 0, 0, '1, '1, '1));
    offer(make_obj(KIND_POINT, 0, 0, -1, 0, 0, 0));
    offer(make_obj(KIND_SPHERE, 0, 0, 0, 0, COORD_MIN, COORD_MIN));
    offer(make_obj(KIND_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
    offer(make_obj(KIND_SPHERE, -65536, 0, 0, 65536, 0, 0));
    offer(make_obj(KIND_SPHERE, 0, 0, 0, -1, 0, 0));
    offer(make_obj(KIND_BAD, '1, '1, '1, '1, '1, '1));
    drain();

    // out-of-range index is dropped; sphere in the far corner with the largest radius
    write_reg(REG_UNUSED, '1);
    load_query(make_obj(KIND_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, '1, '1));
    offer(make_obj(KIND_BOX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    offer(make_obj(KIND_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
    offer(make_obj(KIND_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0));
    offer(make_obj(KIND_SPHERE, COORD_MIN + 100, COORD_MIN, COORD_MIN, -5, 0, 0));
    offer(make_obj(KIND_POINT, -1, COORD_MIN, COORD_MIN, 0, 0, 0));
    drain();

    load_query(make_obj(KIND_POINT, COORD_MAX, COORD_MIN, 0, '1, '1, '1));
    offer(make_obj(KIND_POINT, COORD_MAX, COORD_MIN, 0, 0, 0, 0));
    offer(make_obj(KIND_POINT, COORD_MAX, COORD_MIN, 1, 0, 0, 0));
    offer(make_obj(KIND_BOX, 0, COORD_MIN, -1, COORD_MAX, 0, 0));
    offer(make_obj(KIND_SPHERE, COORD_MAX, COORD_MIN, 0, 0, 0, 0));
    drain();

    // query kind three is not a volume
    load_query(make_obj(KIND_BAD, 0, 0, 0, 0, 0, 0));
    offer(make_obj(KIND_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    offer(make_obj(KIND_SPHERE, 0, 0, 0, COORD_MAX, 0, 0));
    offer(make_obj(KIND_POINT, 0, 0, 0, 0, 0, 0));
    offer(make_obj(KIND_BAD, 0, 0, 0, 0, 0, 0));
    drain();

    // inverted query box
    load_query(make_obj(KIND_BOX, 10, 10, 10, -10, -10, -10));
    offer(make_obj(KIND_BOX, -100, -100, -100, 100, 100, 100));
    offer(make_obj(KIND_SPHERE, 0, 0, 0, 1000, 0, 0));
    offer(make_obj(KIND_POINT, 0, 0, 0, 0, 0, 0));
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_query(rand_query());
      for (int n = 0; n < PHASE_ITEMS; n++) offer(rand_object());
      drain();
    end

    $display("Tested %0d objects (box, sphere, point, invalid) against %0d query settings.",
             n_accepted, n_settings);
    $display("Results checked: %0d, hits: %0d, invalid kinds: %0d.", n_results, n_hits, n_bad);
    if (n_errors == 0) begin
      $display("tb_bounding_volume_overlap_test OK");
    end else begin
      $display("tb_bounding_volume_overlap_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- bounding_volume_overlap_test.f -----
rtl/bvot_pkg.sv
rtl/bvot_prep.sv
rtl/bvot_sqr.sv
rtl/bounding_volume_overlap_test.sv
bench/tb_bounding_volume_overlap_test.sv
